// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== rtl/tirpa_pkg.sv =====
// Shared types, widths and arctangent table for the relative pitch block.
`timescale 1ns / 1ps
package tirpa_pkg;

  localparam int unsigned IN_W             = 16;
  localparam int unsigned NUM_LANES        = 2;
  localparam int unsigned FIELDS_PER_LANE  = 3;
  localparam int unsigned S_TDATA_W        = NUM_LANES * FIELDS_PER_LANE * IN_W;
  localparam int unsigned OUT_W            = 9;
  localparam int unsigned M_TDATA_W        = 16;
  localparam int unsigned SQ_W             = 32;
  localparam int unsigned ROOT_W           = 32;
  localparam int unsigned REM_W            = ROOT_W + 4;
  localparam int unsigned FRAC_BITS        = 16;
  localparam int unsigned VEC_W            = 36;
  localparam int unsigned ANG_W            = 25;
  localparam int unsigned ATAN_ENTRIES     = 24;
  localparam int unsigned ATAN_IDX_W       = 5;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int          ANGLE_MAX        = 180;

  typedef struct packed {
    logic                   x_zero;
    logic signed [IN_W-1:0] x;
    logic [ROOT_W-1:0]      root;
  } sqrt_res_t;

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = ANG_W'(2949120);
      5'd1:    v = ANG_W'(1740967);
      5'd2:    v = ANG_W'(919879);
      5'd3:    v = ANG_W'(466945);
      5'd4:    v = ANG_W'(234379);
      5'd5:    v = ANG_W'(117304);
      5'd6:    v = ANG_W'(58666);
      5'd7:    v = ANG_W'(29335);
      5'd8:    v = ANG_W'(14668);
      5'd9:    v = ANG_W'(7334);
      5'd10:   v = ANG_W'(3667);
      5'd11:   v = ANG_W'(1833);
      5'd12:   v = ANG_W'(917);
      5'd13:   v = ANG_W'(458);
      5'd14:   v = ANG_W'(229);
      5'd15:   v = ANG_W'(115);
      5'd16:   v = ANG_W'(57);
      5'd17:   v = ANG_W'(29);
      5'd18:   v = ANG_W'(14);
      5'd19:   v = ANG_W'(7);
      5'd20:   v = ANG_W'(4);
      5'd21:   v = ANG_W'(2);
      5'd22:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tirpa_isqrt.sv =====
// Per-lane squares and bit-serial square root of the horizontal magnitude.
`timescale 1ns / 1ps
module tirpa_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [tirpa_pkg::IN_W-1:0] x_i,
  input  logic signed [tirpa_pkg::IN_W-1:0] y_i,
  input  logic signed [tirpa_pkg::IN_W-1:0] z_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tirpa_pkg::sqrt_res_t            out_o
);
  import tirpa_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W);

  typedef enum logic [1:0] {ST_IDLE, ST_SQUARE, ST_RUN, ST_DONE} state_e;

  state_e                     state_q;
  logic [CNT_W-1:0]           cnt_q;
  logic signed [2*IN_W-1:0]   ysq_full, zsq_full;
  logic [SQ_W-2:0]            ysq_q, zsq_q;
  logic [SQ_W-1:0]            rad_q;
  logic [REM_W-1:0]           rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0]          root_q, root_d;
  logic signed [IN_W-1:0]     x_q;
  logic                       accept;

  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_DONE);
  assign out_o       = '{x_zero: (x_q == '0), x: x_q, root: root_q};

  assign ysq_full = y_i * y_i;
  assign zsq_full = z_i * z_i;

  // one root bit per cycle, two radicand bits brought down
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE, ST_DONE: begin
          if (accept) begin
            state_q <= ST_SQUARE;
          end else if (state_q == ST_DONE && out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        ST_SQUARE: begin
          cnt_q   <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(ROOT_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ysq_q <= ysq_full[SQ_W-2:0];
      zsq_q <= zsq_full[SQ_W-2:0];
      x_q   <= x_i;
    end
    if (state_q == ST_SQUARE) begin
      rad_q  <= {1'b0, ysq_q} + {1'b0, zsq_q};
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == ST_RUN) begin
      rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

endmodule

// ===== rtl/tirpa_cordic.sv =====
// Per-lane iterative CORDIC in vectoring mode giving pitch in degrees.
`timescale 1ns / 1ps
module tirpa_cordic #(
  parameter int unsigned CORDIC_STEPS = tirpa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tirpa_pkg::sqrt_res_t                in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tirpa_pkg::ANG_W-1:0]  angle_o
);
  import tirpa_pkg::*;

  localparam int unsigned STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_e;

  state_e                  state_q;
  logic [STEP_W-1:0]       cnt_q;
  logic signed [VEC_W-1:0] cx_q, cy_q, dx, dy;
  logic signed [ANG_W-1:0] ang_q, atan_v;
  logic                    zero_q;
  logic                    accept;

  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_DONE);
  assign angle_o     = zero_q ? '0 : ang_q;

  assign dx     = cy_q >>> cnt_q;
  assign dy     = cx_q >>> cnt_q;
  assign atan_v = atan_deg(ATAN_IDX_W'(cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE, ST_DONE: begin
          if (accept) begin
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end else if (state_q == ST_DONE && out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q   <= $signed({{(VEC_W-ROOT_W){1'b0}}, in_i.root});
      cy_q   <= $signed({{(VEC_W-IN_W-FRAC_BITS){in_i.x[IN_W-1]}}, in_i.x,
                         {FRAC_BITS{1'b0}}});
      ang_q  <= '0;
      zero_q <= in_i.x_zero;
    end else if (state_q == ST_RUN) begin
      if (!cy_q[VEC_W-1]) begin
        cx_q  <= cx_q + dx;
        cy_q  <= cy_q - dy;
        ang_q <= ang_q + atan_v;
      end else begin
        cx_q  <= cx_q - dx;
        cy_q  <= cy_q + dy;
        ang_q <= ang_q - atan_v;
      end
    end
  end

endmodule

// ===== rtl/tirpa_merge.sv =====
// Difference of the two lane pitches, truncation to degrees, clamping, output register.
`timescale 1ns / 1ps
module tirpa_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [tirpa_pkg::ANG_W-1:0] fixed_ang_i,
  input  logic signed [tirpa_pkg::ANG_W-1:0] mobile_ang_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tirpa_pkg::OUT_W-1:0] angle_o
);
  import tirpa_pkg::*;

  localparam int unsigned D_W = ANG_W + 1;
  localparam int unsigned Q_W = D_W - FRAC_BITS;

  logic                    vld_q;
  logic signed [OUT_W-1:0] angle_q, angle_d;
  logic signed [D_W-1:0]   diff, adj;
  logic signed [Q_W-1:0]   quo;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign angle_o     = angle_q;

  // bias negative values so the floor shift truncates toward zero
  always_comb begin
    diff = {fixed_ang_i[ANG_W-1], fixed_ang_i} - {mobile_ang_i[ANG_W-1], mobile_ang_i};
    adj  = diff[D_W-1] ? diff + D_W'((1 << FRAC_BITS) - 1) : diff;
    quo  = adj[D_W-1:FRAC_BITS];
    if (quo > Q_W'(ANGLE_MAX)) begin
      angle_d = OUT_W'(ANGLE_MAX);
    end else if (quo < -Q_W'(ANGLE_MAX)) begin
      angle_d = -OUT_W'(ANGLE_MAX);
    end else begin
      angle_d = quo[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      angle_q <= angle_d;
    end
  end

endmodule

// ===== rtl/two_imu_relative_pitch_angle.sv =====
// Relative pitch between two accelerometers: lanes, join logic and top-level ports.
// Each beat carries one x/y/z sample from the fixed and from the mobile sensor; the
// result beat carries fixed pitch minus mobile pitch in whole degrees, truncated toward
// zero and clamped to -180..180, with pitch = atan2(x, sqrt(y*y + z*z)) and a zero x
// giving zero. Both sensors are handled in parallel lanes of identical hardware. A new
// beat is taken only when the square-root units of both lanes are idle or handing on
// their last result; each forms the squares, then settles one root bit per cycle over
// 32 bits. The CORDIC stage and the output register work on earlier beats at the same
// time.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module two_imu_relative_pitch_angle #(
  parameter int unsigned CORDIC_STEPS = tirpa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // fixed_x, fixed_y, fixed_z, mobile_x, mobile_y, mobile_z (16 bits each)
  input  logic [tirpa_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // angle_degrees [8:0], zero padding [15:9]
  output logic [tirpa_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import tirpa_pkg::*;

  logic [NUM_LANES-1:0]    sq_in_ready, sq_valid, co_in_ready, co_valid;
  sqrt_res_t               sq_res [NUM_LANES];
  logic signed [ANG_W-1:0] co_ang [NUM_LANES];
  logic                    sq_to_co, co_to_mg, mg_ready;
  logic signed [OUT_W-1:0] angle;
  logic                    s_beat;
  logic                    angle_oob;

  assign s_axis_tready = &sq_in_ready;
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign sq_to_co      = (&sq_valid) && (&co_in_ready);
  assign co_to_mg      = (&co_valid) && mg_ready;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    tirpa_isqrt u_isqrt (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (s_beat),
      .in_ready_o  (sq_in_ready[l]),
      .x_i         (s_axis_tdata[(l*FIELDS_PER_LANE+0)*IN_W +: IN_W]),
      .y_i         (s_axis_tdata[(l*FIELDS_PER_LANE+1)*IN_W +: IN_W]),
      .z_i         (s_axis_tdata[(l*FIELDS_PER_LANE+2)*IN_W +: IN_W]),
      .out_valid_o (sq_valid[l]),
      .out_ready_i (sq_to_co),
      .out_o       (sq_res[l])
    );

    tirpa_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (sq_to_co),
      .in_ready_o  (co_in_ready[l]),
      .in_i        (sq_res[l]),
      .out_valid_o (co_valid[l]),
      .out_ready_i (co_to_mg),
      .angle_o     (co_ang[l])
    );
  end

  tirpa_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (&co_valid),
    .in_ready_o   (mg_ready),
    .fixed_ang_i  (co_ang[0]),
    .mobile_ang_i (co_ang[1]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .angle_o      (angle)
  );

  assign m_axis_tdata = {{(M_TDATA_W-OUT_W){1'b0}}, angle};

  assign angle_oob = (angle > ANGLE_MAX) || (angle < -ANGLE_MAX);

  `ASSERT_CLK(a_sqrt_lanes_even, sq_valid[0] == sq_valid[1], "square-root lanes out of step")
  `ASSERT_CLK(a_cordic_lanes_even, co_valid[0] == co_valid[1], "CORDIC lanes out of step")
  `ASSERT_CLK(a_busy_after_beat, s_beat |=> !s_axis_tready, "input taken twice in a row")
  `ASSERT_NEVER(a_angle_range, m_axis_tvalid && angle_oob, "angle out of range")

endmodule

// ===== test/two_imu_relative_pitch_angle_checker.sv =====
// Watches both streams of the relative pitch block, predicts each result and compares.
`timescale 1ns / 1ps
module two_imu_relative_pitch_angle_checker #(
  parameter int unsigned CORDIC_STEPS = tirpa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [tirpa_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [tirpa_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  localparam int unsigned TABLE_LEN = 24;

  logic signed [tirpa_pkg::OUT_W-1:0] expected_angle_q[$];

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic longint arctan_step(input int unsigned idx);
    case (idx)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58666;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      15:      return 115;
      16:      return 57;
      17:      return 29;
      18:      return 14;
      19:      return 7;
      20:      return 4;
      21:      return 2;
      22:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] probe;
    rem   = n;
    res   = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // pitch in degrees, 16 fractional bits
  function automatic longint sensor_pitch(input logic signed [15:0] ax,
                                          input logic signed [15:0] ay,
                                          input logic signed [15:0] az);
    logic [63:0] horiz_sq;
    longint      vx;
    longint      vy;
    longint      sx;
    longint      sy;
    longint      tilt;
    if (ax == 0) return 0;
    horiz_sq = 64'(longint'(ay) * longint'(ay)) + 64'(longint'(az) * longint'(az));
    vx   = longint'(floor_root(horiz_sq << 32));
    vy   = longint'(ax) * 65536;
    tilt = 0;
    for (int unsigned i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
      sx = vy >>> i;
      sy = vx >>> i;
      if (vy >= 0) begin
        vx   = vx + sx;
        vy   = vy - sy;
        tilt = tilt + arctan_step(i);
      end else begin
        vx   = vx - sx;
        vy   = vy + sy;
        tilt = tilt - arctan_step(i);
      end
    end
    return tilt;
  endfunction

  function automatic logic signed [tirpa_pkg::OUT_W-1:0] relative_pitch(
      input logic [tirpa_pkg::S_TDATA_W-1:0] beat);
    longint diff;
    longint deg;
    diff = sensor_pitch(beat[15:0], beat[31:16], beat[47:32])
         - sensor_pitch(beat[63:48], beat[79:64], beat[95:80]);
    deg = (diff >= 0) ? (diff >>> tirpa_pkg::FRAC_BITS)
                      : -((-diff) >>> tirpa_pkg::FRAC_BITS);
    if (deg > tirpa_pkg::ANGLE_MAX) deg = tirpa_pkg::ANGLE_MAX;
    if (deg < -tirpa_pkg::ANGLE_MAX) deg = -tirpa_pkg::ANGLE_MAX;
    return tirpa_pkg::OUT_W'(deg);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [tirpa_pkg::OUT_W-1:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      expected_angle_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_angle_q.push_back(relative_pitch(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_angle_q.size() == 0) begin
          $error("unexpected result beat, tdata %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_angle_q.pop_front();
          if (m_axis_tdata[tirpa_pkg::OUT_W-1:0] !== want) begin
            $error("angle_degrees: expected %0d, actual %0d", want,
                   $signed(m_axis_tdata[tirpa_pkg::OUT_W-1:0]));
            fail_count_o <= fail_count_o + 1;
          end else if (m_axis_tdata[tirpa_pkg::M_TDATA_W-1:tirpa_pkg::OUT_W] !== '0) begin
            $error("padding: expected 0, actual %h",
                   m_axis_tdata[tirpa_pkg::M_TDATA_W-1:tirpa_pkg::OUT_W]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_angle_q.size();

endmodule

// ===== test/two_imu_relative_pitch_angle_test.sv =====
// Stimulus and verdict for the relative pitch block; checking sits in the checker module.
`timescale 1ns / 1ps
module two_imu_relative_pitch_angle_test;

  localparam int unsigned PHASE_ITEMS = 350;
  localparam int unsigned HOLD_CYCLES = 600;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tirpa_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tirpa_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                            hold_req = 1'b0;
  int unsigned                     hold_left = 0;
  int unsigned                     idle_pct = 0;
  int unsigned                     stall_pct = 0;
  int unsigned                     fail_count;
  int unsigned                     pending;

  two_imu_relative_pitch_angle i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  two_imu_relative_pitch_angle_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("two_imu_relative_pitch_angle verification failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [tirpa_pkg::S_TDATA_W-1:0] pack_beat(
      input logic [15:0] fx, input logic [15:0] fy, input logic [15:0] fz,
      input logic [15:0] mx, input logic [15:0] my, input logic [15:0] mz);
    return {mz, my, mx, fz, fy, fx};
  endfunction

  function automatic logic [15:0] draw_axis();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // x, y, z of one sensor; flat horizontal and zero x turn up often
  function automatic logic [47:0] draw_sensor();
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    ax = draw_axis();
    ay = draw_axis();
    az = draw_axis();
    if ($urandom_range(9) == 0) begin
      ay = '0;
      az = '0;
    end
    return {az, ay, ax};
  endfunction

  task automatic send_beat(input logic [tirpa_pkg::S_TDATA_W-1:0] beat);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom, $urandom};
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_beat({draw_sensor(), draw_sensor()});
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero x, flat horizontal, full-scale extremes, clamp region
    send_beat(pack_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_beat(pack_beat(16'h0000, 16'h1234, 16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF));
    send_beat(pack_beat(16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000));
    send_beat(pack_beat(16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000));
    send_beat(pack_beat(16'h0001, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
    send_beat(pack_beat(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_beat(pack_beat(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
    send_beat(pack_beat(16'h0001, 16'h8000, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h7FFF));
    send_beat(pack_beat(16'd100, 16'd0, 16'd100, 16'h0000, 16'd5, 16'd5));
    send_beat(pack_beat(16'd100, 16'd100, 16'd0, -16'sd100, 16'd0, -16'sd100));
    send_beat(pack_beat(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0001));
    send_beat(pack_beat(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000));
    send_beat(pack_beat(16'd1000, -16'sd1732, 16'd0, 16'd1732, 16'd0, 16'd1000));
    send_beat(pack_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001));
    send_beat(pack_beat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_beat(pack_beat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    drain();

    idle_pct  = 0;
    stall_pct = 0;
    run_random(PHASE_ITEMS);

    idle_pct  = 80;
    stall_pct = 0;
    run_random(PHASE_ITEMS);

    idle_pct  = 0;
    stall_pct = 80;
    run_random(PHASE_ITEMS);

    // long receiver hold-off while beats keep coming, then light idling on both sides
    idle_pct  = 10;
    stall_pct = 10;
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    run_random(PHASE_ITEMS);

    stall_pct = 0;
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("two_imu_relative_pitch_angle verification clean");
    end else begin
      $display("two_imu_relative_pitch_angle verification failed");
    end
    $finish;
  end

endmodule
